// ===== hdl/ddodo_pkg.sv =====
// Shared types, widths and constant tables for the differential drive odometry block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ddodo_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int FRACTION_BITS     = 16;

    localparam int TRAVEL_W   = 32;
    localparam int POS_W      = 40;
    localparam int ANGLE_W    = 32;
    localparam int WBASE_W    = 31;
    localparam int TSTEP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd1;

    localparam logic [WBASE_W-1:0] WHEEL_BASE_RST = 31'd2621440;
    localparam logic [TSTEP_W-1:0] TIME_STEP_RST  = 16'd256;

    // |left - right| * time_step fits in 48 bits
    localparam int MAG_W      = 48;
    localparam int DIVIDEND_W = MAG_W + FRACTION_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    // quotient bits that reach the turn increments
    localparam int QUOT_W     = FRACTION_BITS + 41;
    localparam int ACC_W      = QUOT_W;
    localparam int NCHUNK     = (QUOT_W + 31) / 32;
    localparam int CHUNK_W    = $clog2(NCHUNK);

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int CORDIC_W = 34 + FRACTION_BITS;
    localparam int ROT_W    = CORDIC_W - FRACTION_BITS;
    localparam int Z_W      = 34;
    localparam int ITER_W   = 5;

    localparam logic [MUL_B_W-1:0] TURN_SCALE  = 32'd683565276;
    localparam logic [MUL_B_W-1:0] CORDIC_GAIN = 32'd2608131497;

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== hdl/ddodo_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ddodo_pkg for widths.
`timescale 1ns / 1ps

module ddodo_div
    import ddodo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [WBASE_W-1:0]    divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] sr_reg, sr_next;
    logic [WBASE_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic [WBASE_W:0]      rem_sh;
    logic                  ge;

    always_comb
    begin
        rem_sh    = {rem_reg, sr_reg[DIVIDEND_W-1]};
        ge        = rem_sh >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sr_next   = sr_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            sr_next   = dividend;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            sr_next  = {sr_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next = ge ? WBASE_W'(rem_sh - {1'b0, divisor}) : WBASE_W'(rem_sh);
            q_next   = {q_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg  <= sr_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== hdl/ddodo_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ddodo_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module ddodo_cordic
    import ddodo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [CORDIC_W-1:0] x_init,
    input  logic [ANGLE_W-1:0]         angle,
    output logic                       done,
    output logic signed [ROT_W-1:0]    cos_out,
    output logic signed [ROT_W-1:0]    sin_out
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ITER_W-1:0]          i_reg, i_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]      z_reg, z_next;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]      step_z;
    logic                       flip;
    logic [ANGLE_W-1:0]         ang_adj;

    always_comb
    begin
        // second and third quadrant: rotate by a half turn first
        flip      = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
        ang_adj   = {angle[ANGLE_W-1] ^ flip, angle[ANGLE_W-2:0]};
        dx        = y_reg >>> i_reg;
        dy        = x_reg >>> i_reg;
        step_z    = Z_W'(ATAN_BAM[i_reg]);
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next    = '0;
            x_next    = flip ? -x_init : x_init;
            y_next    = '0;
            z_next    = Z_W'($signed(ang_adj));
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_z;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_z;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == ITER_W'(CORDIC_ITERATIONS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = done_reg;
    assign cos_out = x_reg[CORDIC_W-1:FRACTION_BITS];
    assign sin_out = y_reg[CORDIC_W-1:FRACTION_BITS];

endmodule

// ===== hdl/differential_drive_odometry_top.sv =====
// Top level of the differential drive odometry block: sequencer, shared multiplier, pose state.
// Depends on ddodo_pkg, ddodo_div and ddodo_cordic.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one beat per odometry step:
//   left_travel and right_travel, signed Q16.16 cm.
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   pose_x, pose_y (Q24.16, saturating) and pose_heading (binary angle).
//   Config: cfg_we with cfg_index 0 = wheel_base, 1 = time_step; other
//   indexes are ignored. Write only while the block is idle.
//   One step at a time: most of the time per step goes to the 64-bit
//   radix-2 turn divider and the 24 CORDIC micro-rotations; one 33x32
//   multiplier is shared for travel scaling, CORDIC gain and turn scaling.
//   in_ready is high whenever the sequencer is idle, even while a result
//   still waits; a stalled result holds and the next step's pose update
//   waits until it is taken.
//   Reset clears the pose to zero and loads wheel_base = 40 cm and
//   time_step = 1.0.

module differential_drive_odometry_top
    import ddodo_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [TRAVEL_W-1:0]  left_travel,
    input  logic signed [TRAVEL_W-1:0]  right_travel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [POS_W-1:0]     pose_x,
    output logic signed [POS_W-1:0]     pose_y,
    output logic [ANGLE_W-1:0]          pose_heading,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAG  = 3'd1;
    localparam logic [2:0] S_GAIN = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_TURN = 3'd4;
    localparam logic [2:0] S_ROTS = 3'd5;
    localparam logic [2:0] S_ROT  = 3'd6;
    localparam logic [2:0] S_UPD  = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [WBASE_W-1:0]         wheel_base_reg;
    logic [TSTEP_W-1:0]         time_step_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]    pos_y_reg, pos_y_next;
    logic [ANGLE_W-1:0]         heading_reg, heading_next;

    logic [TRAVEL_W-1:0]        sabs_reg, sabs_next;
    logic                       sneg_reg, sneg_next;
    logic [MUL_A_W-1:0]         adiff_reg, adiff_next;
    logic                       neg_reg, neg_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic signed [CORDIC_W-1:0] x0_reg, x0_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [CHUNK_W-1:0]         chunk_reg, chunk_next;

    logic signed [TRAVEL_W:0]   sum_lr, diff_lr;
    logic [TRAVEL_W-1:0]        s_half;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          prod;
    logic [NCHUNK*32-1:0]       q_pad;
    logic [CORDIC_W-1:0]        gain_mag;
    logic [ANGLE_W-1:0]         full_raw, half_raw, full_inc, half_inc;
    logic signed [POS_W:0]      sum_x, sum_y;

    logic                       div_start, div_done;
    logic [QUOT_W-1:0]          quot;
    logic [WBASE_W-1:0]         divisor;
    logic                       cor_start, cor_done;
    logic signed [ROT_W-1:0]    cos_x, sin_y;
    logic                       upd_fire;

    ddodo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag_reg, {FRACTION_BITS{1'b0}}}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quot)
    );

    ddodo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .x_init  (x0_reg),
        .angle   (heading_reg + half_inc),
        .done    (cor_done),
        .cos_out (cos_x),
        .sin_out (sin_y)
    );

    // shared multiplier
    always_comb
    begin
        q_pad = (NCHUNK*32)'(quot);
        case (state_reg)
            S_MAG:
            begin
                mul_a = adiff_reg;
                mul_b = MUL_B_W'(time_step_reg);
            end
            S_GAIN:
            begin
                mul_a = MUL_A_W'(sabs_reg);
                mul_b = CORDIC_GAIN;
            end
            S_TURN:
            begin
                mul_a = MUL_A_W'(q_pad[{chunk_reg, 5'b0} +: 32]);
                mul_b = TURN_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        sum_lr   = (TRAVEL_W+1)'(left_travel) + (TRAVEL_W+1)'(right_travel);
        diff_lr  = (TRAVEL_W+1)'(left_travel) - (TRAVEL_W+1)'(right_travel);
        s_half   = sum_lr[TRAVEL_W:1];
        divisor  = (wheel_base_reg == '0) ? WBASE_W'(1) : wheel_base_reg;
        gain_mag = CORDIC_W'(prod[63:32-FRACTION_BITS]);
        full_raw = acc_reg[FRACTION_BITS+8 +: ANGLE_W];
        half_raw = acc_reg[FRACTION_BITS+9 +: ANGLE_W];
        full_inc = neg_reg ? -full_raw : full_raw;
        half_inc = neg_reg ? -half_raw : half_raw;
        sum_x    = (POS_W+1)'(pos_x_reg) + (POS_W+1)'(cos_x);
        sum_y    = (POS_W+1)'(pos_y_reg) + (POS_W+1)'(sin_y);
        upd_fire = (state_reg == S_UPD) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        sabs_next      = sabs_reg;
        sneg_next      = sneg_reg;
        adiff_next     = adiff_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        x0_next        = x0_reg;
        acc_next       = acc_reg;
        chunk_next     = chunk_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        heading_next   = heading_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        cor_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sneg_next  = s_half[TRAVEL_W-1];
                    sabs_next  = s_half[TRAVEL_W-1] ? -s_half : s_half;
                    neg_next   = diff_lr[TRAVEL_W];
                    adiff_next = diff_lr[TRAVEL_W] ? MUL_A_W'(-diff_lr) : MUL_A_W'(diff_lr);
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                mag_next   = prod[MAG_W-1:0];
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                x0_next    = sneg_reg ? -$signed(gain_mag) : $signed(gain_mag);
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = '0;
                    chunk_next = CHUNK_W'(NCHUNK - 1);
                    state_next = S_TURN;
                end
            end
            S_TURN:
            begin
                // top chunk first: acc = acc * 2^32 + chunk * scale
                acc_next = ACC_W'({acc_reg, 32'h0}) + ACC_W'(prod);
                if (chunk_reg == '0)
                begin
                    state_next = S_ROTS;
                end
                else
                begin
                    chunk_next = chunk_reg - 1'b1;
                end
            end
            S_ROTS:
            begin
                cor_start  = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (cor_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (upd_fire)
                begin
                    if (sum_x[POS_W] != sum_x[POS_W-1])
                    begin
                        pos_x_next = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : {1'b0, {(POS_W-1){1'b1}}};
                    end
                    else
                    begin
                        pos_x_next = sum_x[POS_W-1:0];
                    end
                    if (sum_y[POS_W] != sum_y[POS_W-1])
                    begin
                        pos_y_next = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : {1'b0, {(POS_W-1){1'b1}}};
                    end
                    else
                    begin
                        pos_y_next = sum_y[POS_W-1:0];
                    end
                    heading_next   = heading_reg + full_inc;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            wheel_base_reg <= WHEEL_BASE_RST;
            time_step_reg  <= TIME_STEP_RST;
            chunk_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            heading_reg   <= heading_next;
            chunk_reg     <= chunk_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WHEEL_BASE: wheel_base_reg <= cfg_data[WBASE_W-1:0];
                    REG_TIME_STEP:  time_step_reg  <= cfg_data[TSTEP_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sabs_reg  <= sabs_next;
        sneg_reg  <= sneg_next;
        adiff_reg <= adiff_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        x0_reg    <= x0_next;
        acc_reg   <= acc_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign pose_x       = pos_x_reg;
    assign pose_y       = pos_y_reg;
    assign pose_heading = heading_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a step is in flight");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cor_done |-> state_reg == S_ROT)
        else $error("rotation finished outside the rotate phase");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_UPD)
        else $error("result raised without a pose update");

endmodule

// ===== tb/sv/tb_differential_drive_odometry_top.sv =====
// Self-checking testbench for differential_drive_odometry_top: a directed step list, then random
// and drive-run steps, each pose checked against a dead-reckoning predictor kept in the bench.
// Depends on ddodo_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_differential_drive_odometry_top;
    import ddodo_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [ANGLE_W-1:0] heading;
    } pose_t;

    typedef struct packed {
        logic [TRAVEL_W-1:0] left;
        logic [TRAVEL_W-1:0] right;
        logic                fixed;
        pose_t               pose;
    } step_row_t;

    typedef enum logic [1:0] { IDLE_TX_LIGHT, IDLE_TX_HEAVY, IDLE_NONE } idle_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO = -(longint'(1) <<< (POS_W - 1));
    localparam logic [ANGLE_W-1:0] HEADING_NW = 32'h6000_0000;
    localparam pose_t POSE_ORIGIN = '{x: '0, y: '0, heading: '0};
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int DIR_ROWS     = 24;
    localparam int REPORT_CAP   = 50;

    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [TRAVEL_W-1:0] left_travel  = '0;
    logic signed [TRAVEL_W-1:0] right_travel = '0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [POS_W-1:0]    pose_x;
    logic signed [POS_W-1:0]    pose_y;
    logic [ANGLE_W-1:0]         pose_heading;
    logic                       cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;

    // predictor state and register copies
    longint               odo_x          = 0;
    longint               odo_y          = 0;
    logic [ANGLE_W-1:0]   odo_heading    = '0;
    logic [WBASE_W-1:0]   wheel_base_reg = WHEEL_BASE_RST;
    logic [TSTEP_W-1:0]   time_step_reg  = TIME_STEP_RST;

    pose_t      pose_q [$];
    pose_t      expected_pose;
    int         errors        = 0;
    int         steps_sent    = 0;
    int         poses_checked = 0;
    int         settings_used = 1;
    int         tx_pct        = 0;
    int         rx_pct        = 0;
    longint     cycle_count   = 0;

    step_row_t dir_table [DIR_ROWS] = '{
        '{32'sd0,           32'sd0,           1'b1, POSE_ORIGIN},
        '{32'sh0001_0000,   32'sh0001_0000,   1'b0, POSE_ORIGIN},
        '{32'sh7FFF_FFFF,   32'sh7FFF_FFFF,   1'b0, POSE_ORIGIN},
        '{32'sh8000_0000,   32'sh8000_0000,   1'b0, POSE_ORIGIN},
        '{32'sh7FFF_FFFF,   32'sh8000_0000,   1'b0, POSE_ORIGIN},
        '{32'sh8000_0000,   32'sh7FFF_FFFF,   1'b0, POSE_ORIGIN},
        '{32'sh7FFF_FFFF,   32'sd0,           1'b0, POSE_ORIGIN},
        '{32'sd0,           32'sh8000_0000,   1'b0, POSE_ORIGIN},
        '{32'sd1,           32'sd0,           1'b0, POSE_ORIGIN},
        '{32'sd0,           32'sd1,           1'b0, POSE_ORIGIN},
        '{-32'sd1,          -32'sd1,          1'b0, POSE_ORIGIN},
        '{-32'sd1,          32'sd0,           1'b0, POSE_ORIGIN},
        '{32'sd2058869,     -32'sd2058869,    1'b0, POSE_ORIGIN},
        '{32'sh0010_0000,   32'sh0010_0000,   1'b0, POSE_ORIGIN},
        '{32'sd2058869,     -32'sd2058869,    1'b0, POSE_ORIGIN},
        '{32'sh0010_0000,   32'sh0010_0000,   1'b0, POSE_ORIGIN},
        '{32'sd2058869,     -32'sd2058869,    1'b0, POSE_ORIGIN},
        '{32'sh0010_0000,   32'sh0010_0000,   1'b0, POSE_ORIGIN},
        '{32'sd2058869,     -32'sd2058869,    1'b0, POSE_ORIGIN},
        '{32'sh0020_0000,   32'sh0018_0000,   1'b0, POSE_ORIGIN},
        '{32'sh0018_0000,   32'sh0020_0000,   1'b0, POSE_ORIGIN},
        '{32'sh5555_5555,   32'shAAAA_AAAA,   1'b0, POSE_ORIGIN},
        '{32'shAAAA_AAAA,   32'sh5555_5555,   1'b0, POSE_ORIGIN},
        '{32'sh0000_8000,   32'shFFFF_8000,   1'b0, POSE_ORIGIN}
    };

    differential_drive_odometry_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_travel  (left_travel),
        .right_travel (right_travel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    // heading increments for a travel difference: whole step and half step
    function automatic void turn_delta(input longint diff, output logic [31:0] full,
                                       output logic [31:0] half);
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  divisor;
        logic [63:0]  quot;
        logic [127:0] prod;
        neg     = diff < 0;
        mag     = neg ? -diff : diff;
        mag     = mag * time_step_reg;
        divisor = (wheel_base_reg == '0) ? 64'd1 : 64'(wheel_base_reg);
        quot    = (mag << FRACTION_BITS) / divisor;
        prod    = 128'(quot) * 128'(TURN_SCALE);
        full    = prod[FRACTION_BITS + 8 +: 32];
        half    = prod[FRACTION_BITS + 9 +: 32];
        if (neg)
        begin
            full = -full;
            half = -half;
        end
    endfunction

    function automatic void rotate_travel(input longint s, input logic [31:0] ang,
                                          output longint cx, output longint sy);
        longint unsigned amag;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          step_angle;
        int              i;
        amag = (s < 0) ? -s : s;
        x    = (amag * 64'(CORDIC_GAIN)) >> (32 - FRACTION_BITS);
        if (s < 0)
            x = -x;
        if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10)
        begin
            x   = -x;
            ang = ang - 32'h8000_0000;
        end
        y = 0;
        z = $signed(ang);
        for (i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            dx         = y >>> i;
            dy         = x >>> i;
            step_angle = ATAN_BAM[i];
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - step_angle;
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + step_angle;
            end
        end
        cx = x >>> FRACTION_BITS;
        sy = y >>> FRACTION_BITS;
    endfunction

    function automatic pose_t advance_pose(input logic [31:0] left, input logic [31:0] right);
        longint      l;
        longint      r;
        longint      s;
        longint      dx;
        longint      dy;
        logic [31:0] full;
        logic [31:0] half;
        pose_t       p;
        l = $signed(left);
        r = $signed(right);
        s = (l + r) >>> 1;
        turn_delta(l - r, full, half);
        rotate_travel(s, odo_heading + half, dx, dy);
        odo_x       = clamp_pos(odo_x + dx);
        odo_y       = clamp_pos(odo_y + dy);
        odo_heading = odo_heading + full;
        p.x         = odo_x[POS_W-1:0];
        p.y         = odo_y[POS_W-1:0];
        p.heading   = odo_heading;
        return p;
    endfunction

    function automatic logic [31:0] extreme_travel();
        case ($urandom_range(5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < REPORT_CAP)
            $display("[%0t] pose mismatch on %s: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_TX_LIGHT:
            begin
                tx_pct = 26;
                rx_pct = 65;
            end
            IDLE_TX_HEAVY:
            begin
                tx_pct = 65;
                rx_pct = 26;
            end
            default:
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
        endcase
    endtask

    task automatic send_step(input logic [31:0] left, input logic [31:0] right,
                             input logic fixed, input pose_t fixed_pose);
        pose_t p;
        if (tx_pct != 0 && $urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(130, 1)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        left_travel  <= left;
        right_travel <= right;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = advance_pose(left, right);
        if (fixed)
            p = fixed_pose;
        pose_q = {pose_q, p};
        steps_sent++;
    endtask

    task automatic send_random();
        logic [31:0] l;
        logic [31:0] r;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            l = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            r = l + $urandom_range(32'h0002_0000) - 32'h0001_0000;
        end
        else if (pick < 70)
        begin
            l = $urandom;
            r = $urandom;
        end
        else if (pick < 80)
        begin
            l = extreme_travel();
            r = extreme_travel();
        end
        else if (pick < 90)
        begin
            l = $urandom;
            r = -l;
        end
        else
        begin
            l = $urandom;
            r = l;
        end
        send_step(l, r, 1'b0, POSE_ORIGIN);
    endtask

    // drop valid, let every pose come back, then write the registers
    task automatic next_setting(input logic [WBASE_W-1:0] wb, input logic [CFG_DATA_W-1:0] ts_word,
                                input logic spare);
        in_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WHEEL_BASE;
        cfg_data  <= wb;
        @(posedge clk);
        cfg_index <= REG_TIME_STEP;
        cfg_data  <= ts_word;
        @(posedge clk);
        if (spare)
        begin
            cfg_index <= REG_SPARE_A;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
            cfg_index <= REG_SPARE_B;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        wheel_base_reg = wb;
        time_step_reg  = ts_word[TSTEP_W-1:0];
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_q.size() == 0)
            begin
                report_mismatch("unexpected beat", 64'(pose_x[POS_W-1:0]), '0);
            end
            else
            begin
                expected_pose = pose_q.pop_front();
                if (pose_x !== expected_pose.x)
                    report_mismatch("pose_x", 64'(pose_x[POS_W-1:0]), 64'(expected_pose.x));
                if (pose_y !== expected_pose.y)
                    report_mismatch("pose_y", 64'(pose_y[POS_W-1:0]), 64'(expected_pose.y));
                if (pose_heading !== expected_pose.heading)
                    report_mismatch("pose_heading", 64'(pose_heading),
                                    64'(expected_pose.heading));
                poses_checked++;
            end
        end
    end

    // output side: random back-pressure with occasional long stalls, none while rx_pct is zero
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_pct != 0 && $urandom_range(999) < 4)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(150, 20)) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_pct);
            end
        end
    end

    initial
    begin
        longint      heading_turn;
        logic [31:0] lt;
        logic [31:0] rt;
        int          held;
        int          k;
        set_idle(IDLE_TX_LIGHT);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_step(dir_table[k].left, dir_table[k].right, dir_table[k].fixed,
                      dir_table[k].pose);

        next_setting(31'd65536, 31'd65535, 1'b0);
        for (k = 0; k < 60; k++)
            send_random();

        set_idle(IDLE_TX_HEAVY);
        next_setting(31'h7FFF_FFFF, 31'd1, 1'b0);
        for (k = 0; k < 60; k++)
            send_random();

        // long drive to the north-west until x pins low and y pins high
        next_setting(WHEEL_BASE_RST, 31'(TIME_STEP_RST), 1'b1);
        heading_turn = $signed(HEADING_NW - odo_heading);
        lt = 32'(heading_turn * longint'(WHEEL_BASE_RST) / longint'(TURN_SCALE) / 2);
        send_step(lt, -lt, 1'b0, POSE_ORIGIN);
        held = 0;
        for (k = 0; k < 600 && held <= 15; k++)
        begin
            if (odo_x == POS_LO && odo_y == POS_HI)
                held++;
            lt = 32'h7FFF_0000 | $urandom_range(16'hFFFF);
            rt = lt ^ $urandom_range(255);
            send_step(lt, rt, 1'b0, POSE_ORIGIN);
        end

        // zero wheel base and zero time step
        set_idle(IDLE_NONE);
        next_setting('0, '0, 1'b0);
        for (k = 0; k < 40; k++)
            send_random();

        next_setting(WBASE_W'($urandom_range(32'h7FFF_FFFF, 32'h0001_0000)),
                     {15'($urandom), 16'($urandom_range(65535, 1))}, 1'b0);
        for (k = 0; k < 60; k++)
            send_random();

        in_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("odometry run: %0d steps, %0d poses checked, %0d register settings",
                 steps_sent, poses_checked, settings_used);
        $display("register extremes, zero wheel base and time step, full-range travel, saturation");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
